>>> hdl/idll_pkg.sv
package idll_pkg;

	localparam int POOL_SLOTS_DEF = 256;

	localparam int KIND_W   = 3;
	localparam int VALUE_W  = 32;
	localparam int POS_W    = 9;
	localparam int STATUS_W = 2;
	localparam int FIDX_W   = 8;
	localparam int COUNT_W  = 9;

	typedef logic [KIND_W-1:0]          kind_t;
	typedef logic signed [VALUE_W-1:0]  value_t;
	typedef logic [POS_W-1:0]           pos_t;
	typedef logic [STATUS_W-1:0]        status_t;
	typedef logic [FIDX_W-1:0]          fidx_t;
	typedef logic [COUNT_W-1:0]         count_t;

	localparam kind_t KIND_INSERT = 3'd0;
	localparam kind_t KIND_DELETE = 3'd1;
	localparam kind_t KIND_READ   = 3'd2;
	localparam kind_t KIND_FIND   = 3'd3;
	localparam kind_t KIND_CLEAR  = 3'd4;

	localparam status_t STATUS_OK        = 2'd0;
	localparam status_t STATUS_RANGE     = 2'd1;
	localparam status_t STATUS_FULL      = 2'd2;
	localparam status_t STATUS_NOT_FOUND = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_POP,
		ST_WALK,
		ST_FIND,
		ST_LINK_PREV,
		ST_LINK_NEXT,
		ST_DONE
	} state_t;

	// node memory command: one read or a per-field write per cycle
	typedef struct packed {
		logic re;
		logic we_value;
		logic we_next;
		logic we_prev;
	} node_cmd_t;

	typedef struct packed {
		logic pop;
		logic push;
		logic clear;
	} free_cmd_t;

endpackage

>>> hdl/idll_ifs.sv
interface idll_req_if;
	import idll_pkg::*;
	logic   valid;
	logic   ready;
	kind_t  kind;
	value_t value;
	pos_t   position;
	modport source(output valid, kind, value, position, input ready);
	modport sink(input valid, kind, value, position, output ready);
endinterface

interface idll_rsp_if;
	import idll_pkg::*;
	logic    valid;
	logic    ready;
	status_t status;
	value_t  read_value;
	fidx_t   found_index;
	count_t  count;
	modport source(output valid, status, read_value, found_index, count, input ready);
	modport sink(input valid, status, read_value, found_index, count, output ready);
endinterface

>>> hdl/idll_node_mem.sv
module idll_node_mem #(
	parameter int POOL_SLOTS = idll_pkg::POOL_SLOTS_DEF,
	localparam int SW = $clog2(POOL_SLOTS)
) (
	input  logic                               clk,
	input  idll_pkg::node_cmd_t                cmd,
	input  logic [SW-1:0]                      addr,
	input  logic signed [idll_pkg::VALUE_W-1:0] wvalue,
	input  logic [SW-1:0]                      wnext,
	input  logic [SW-1:0]                      wprev,
	output logic signed [idll_pkg::VALUE_W-1:0] rvalue,
	output logic [SW-1:0]                      rnext,
	output logic [SW-1:0]                      rprev
);
	import idll_pkg::*;

	value_t        value_mem [POOL_SLOTS];
	logic [SW-1:0] next_mem  [POOL_SLOTS];
	logic [SW-1:0] prev_mem  [POOL_SLOTS];

	always_ff @(posedge clk) begin
		if (cmd.we_value) begin
			value_mem[addr] <= wvalue;
		end
		if (cmd.we_next) begin
			next_mem[addr] <= wnext;
		end
		if (cmd.we_prev) begin
			prev_mem[addr] <= wprev;
		end
		if (cmd.re) begin
			rvalue <= value_mem[addr];
			rnext  <= next_mem[addr];
			rprev  <= prev_mem[addr];
		end
	end

endmodule

>>> hdl/idll_free_stack.sv
module idll_free_stack #(
	parameter int POOL_SLOTS = idll_pkg::POOL_SLOTS_DEF,
	localparam int SW = $clog2(POOL_SLOTS),
	localparam int CW = $clog2(POOL_SLOTS + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  idll_pkg::free_cmd_t cmd,
	input  logic [SW-1:0]       push_slot,
	output logic [SW-1:0]       pop_slot,
	output logic [CW-1:0]       top
);
	import idll_pkg::*;

	// Entries below the low-water mark were never written since the last
	// clear and read back as their own index; no clearing pass needed.
	logic [SW-1:0] stack_mem [POOL_SLOTS];
	logic [CW-1:0] top_q;
	logic [CW-1:0] low_q;
	logic [CW-1:0] top_m1;
	logic          push_ok;
	logic          hit_s1;
	logic [SW-1:0] idx_s1;
	logic [SW-1:0] rdata_s1;

	assign top_m1  = top_q - CW'(1);
	assign push_ok = cmd.push && (top_q < CW'(POOL_SLOTS));
	assign top     = top_q;
	assign pop_slot = hit_s1 ? idx_s1 : rdata_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q <= CW'(POOL_SLOTS);
			low_q <= CW'(POOL_SLOTS);
		end else if (cmd.clear) begin
			top_q <= CW'(POOL_SLOTS);
			low_q <= CW'(POOL_SLOTS);
		end else if (cmd.pop) begin
			top_q <= top_m1;
			if (top_q == low_q) begin
				low_q <= top_m1;
			end
		end else if (push_ok) begin
			top_q <= top_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push_ok) begin
			stack_mem[top_q[SW-1:0]] <= push_slot;
		end
		if (cmd.pop) begin
			rdata_s1 <= stack_mem[top_m1[SW-1:0]];
			hit_s1   <= (top_q == low_q);
			idx_s1   <= top_m1[SW-1:0];
		end
	end

endmodule

>>> hdl/indexed_double_linked_list_unit.sv
// Channel | Dir | Modport        | Payload
// req     | in  | idll_req_if    | kind, value, position
// rsp     | out | idll_rsp_if    | status, read_value, found_index, count
//
// One operation at a time; each transfer on req yields one transfer on rsp.
// Positional ops walk one node per cycle (node memory read -> next address),
// from the head or the tail, then rewrite the affected links.
// Find walks from the head until a match or the last node. Clear and errors skip the walk.
// Reset takes effect at once: the free stack uses a low-water mark, no sweep.
// A finished result waits in the rsp register while the next req is taken.
module indexed_double_linked_list_unit #(
	parameter int POOL_SLOTS = idll_pkg::POOL_SLOTS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	idll_req_if.sink  req,
	idll_rsp_if.source rsp
);
	import idll_pkg::*;

	localparam int SW = $clog2(POOL_SLOTS);
	localparam int CW = $clog2(POOL_SLOTS + 1);
	localparam int XW = (CW > POS_W) ? CW : POS_W;

	state_t        state_q, state_d;
	kind_t         kind_q, kind_d;
	value_t        val_q, val_d;
	logic [XW-1:0] pos_q, pos_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [SW-1:0] head_q, head_d, tail_q, tail_d;
	logic [SW-1:0] cur_q, cur_d;
	logic [CW-1:0] steps_q, steps_d;
	logic          dir_q, dir_d;          // 1: follow next links
	logic [CW-1:0] idx_q, idx_d;
	logic [SW-1:0] n_q, n_d;              // freshly popped slot
	logic [SW-1:0] lp_addr_q, lp_addr_d, lp_val_q, lp_val_d;
	logic [SW-1:0] ln_addr_q, ln_addr_d, ln_val_q, ln_val_d;
	logic          chain_q, chain_d;
	status_t       status_q, status_d;
	value_t        rd_q, rd_d;
	fidx_t         fidx_q, fidx_d;

	logic          rsp_valid_q;
	status_t       rsp_status_q;
	value_t        rsp_value_q;
	fidx_t         rsp_fidx_q;
	count_t        rsp_count_q;
	logic          out_load;

	node_cmd_t     nm_cmd;
	logic [SW-1:0] nm_addr, nm_wn, nm_wp, nm_rn, nm_rp;
	value_t        nm_wv, nm_rv;
	free_cmd_t     fs_cmd;
	logic [SW-1:0] fs_pop_slot;
	logic [CW-1:0] fs_top;

	logic [XW-1:0] cnt_x;
	logic          from_head;
	logic [SW-1:0] walk_start;
	logic [CW-1:0] walk_steps;
	logic [SW-1:0] step_addr;

	idll_node_mem #(.POOL_SLOTS(POOL_SLOTS)) u_nodes (
		.clk    (clk),
		.cmd    (nm_cmd),
		.addr   (nm_addr),
		.wvalue (nm_wv),
		.wnext  (nm_wn),
		.wprev  (nm_wp),
		.rvalue (nm_rv),
		.rnext  (nm_rn),
		.rprev  (nm_rp)
	);

	idll_free_stack #(.POOL_SLOTS(POOL_SLOTS)) u_free (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (fs_cmd),
		.push_slot (cur_q),
		.pop_slot  (fs_pop_slot),
		.top       (fs_top)
	);

	// walk setup: from the head when count/2 > index, else from the tail
	assign cnt_x      = XW'(cnt_q);
	assign from_head  = (cnt_x >> 1) > pos_q;
	assign walk_start = from_head ? head_q : tail_q;
	assign walk_steps = from_head ? CW'(pos_q) : CW'(cnt_x - XW'(1) - pos_q);
	assign step_addr  = dir_q ? nm_rn : nm_rp;

	assign req.ready       = (state_q == ST_IDLE);
	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = rsp_status_q;
	assign rsp.read_value  = rsp_value_q;
	assign rsp.found_index = rsp_fidx_q;
	assign rsp.count       = rsp_count_q;

	always_comb begin
		state_d   = state_q;
		kind_d    = kind_q;
		val_d     = val_q;
		pos_d     = pos_q;
		cnt_d     = cnt_q;
		head_d    = head_q;
		tail_d    = tail_q;
		cur_d     = cur_q;
		steps_d   = steps_q;
		dir_d     = dir_q;
		idx_d     = idx_q;
		n_d       = n_q;
		lp_addr_d = lp_addr_q;
		lp_val_d  = lp_val_q;
		ln_addr_d = ln_addr_q;
		ln_val_d  = ln_val_q;
		chain_d   = chain_q;
		status_d  = status_q;
		rd_d      = rd_q;
		fidx_d    = fidx_q;
		nm_cmd    = '0;
		nm_addr   = cur_q;
		nm_wv     = val_q;
		nm_wn     = n_q;
		nm_wp     = n_q;
		fs_cmd    = '0;
		out_load  = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					kind_d  = req.kind;
					val_d   = req.value;
					pos_d   = XW'(req.position);
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				status_d = STATUS_OK;
				rd_d     = '0;
				fidx_d   = '0;
				state_d  = ST_DONE;
				unique case (kind_q)
					KIND_INSERT: begin
						if (pos_q > cnt_x) begin
							status_d = STATUS_RANGE;
						end else if (fs_top == '0 || cnt_q >= CW'(POOL_SLOTS)) begin
							status_d = STATUS_FULL;
						end else begin
							fs_cmd.pop = 1'b1;
							state_d    = ST_POP;
						end
					end
					KIND_DELETE, KIND_READ: begin
						if (pos_q >= cnt_x) begin
							status_d = STATUS_RANGE;
							if (kind_q == KIND_READ) begin
								rd_d = '1;
							end
						end else begin
							nm_cmd.re = 1'b1;
							nm_addr   = walk_start;
							cur_d     = walk_start;
							steps_d   = walk_steps;
							dir_d     = from_head;
							state_d   = ST_WALK;
						end
					end
					KIND_FIND: begin
						if (cnt_q == '0) begin
							status_d = STATUS_NOT_FOUND;
						end else begin
							nm_cmd.re = 1'b1;
							nm_addr   = head_q;
							cur_d     = head_q;
							idx_d     = '0;
							state_d   = ST_FIND;
						end
					end
					KIND_CLEAR: begin
						fs_cmd.clear = 1'b1;
						head_d       = '0;
						tail_d       = '0;
						cnt_d        = '0;
					end
					default: begin
					end
				endcase
			end
			ST_POP: begin
				n_d = fs_pop_slot;
				if (cnt_q == '0) begin
					// first element links to itself
					nm_addr = fs_pop_slot;
					nm_cmd  = '{re: 1'b0, we_value: 1'b1, we_next: 1'b1, we_prev: 1'b1};
					nm_wn   = fs_pop_slot;
					nm_wp   = fs_pop_slot;
					head_d  = fs_pop_slot;
					tail_d  = fs_pop_slot;
					cnt_d   = cnt_q + CW'(1);
					state_d = ST_DONE;
				end else if (pos_q == '0) begin
					nm_addr   = fs_pop_slot;
					nm_cmd    = '{re: 1'b0, we_value: 1'b1, we_next: 1'b1, we_prev: 1'b1};
					nm_wn     = head_q;
					nm_wp     = fs_pop_slot;
					lp_addr_d = head_q;
					lp_val_d  = fs_pop_slot;
					chain_d   = 1'b0;
					head_d    = fs_pop_slot;
					cnt_d     = cnt_q + CW'(1);
					state_d   = ST_LINK_PREV;
				end else if (pos_q == cnt_x) begin
					nm_addr   = fs_pop_slot;
					nm_cmd    = '{re: 1'b0, we_value: 1'b1, we_next: 1'b1, we_prev: 1'b1};
					nm_wn     = fs_pop_slot;
					nm_wp     = tail_q;
					ln_addr_d = tail_q;
					ln_val_d  = fs_pop_slot;
					tail_d    = fs_pop_slot;
					cnt_d     = cnt_q + CW'(1);
					state_d   = ST_LINK_NEXT;
				end else begin
					nm_cmd.re = 1'b1;
					nm_addr   = walk_start;
					cur_d     = walk_start;
					steps_d   = walk_steps;
					dir_d     = from_head;
					state_d   = ST_WALK;
				end
			end
			ST_WALK: begin
				if (steps_q != '0) begin
					nm_cmd.re = 1'b1;
					nm_addr   = step_addr;
					cur_d     = step_addr;
					steps_d   = steps_q - CW'(1);
				end else begin
					state_d = ST_DONE;
					unique case (kind_q)
						KIND_READ: begin
							rd_d = nm_rv;
						end
						KIND_DELETE: begin
							fs_cmd.push = 1'b1;
							cnt_d       = cnt_q - CW'(1);
							if (cnt_q == CW'(1)) begin
								head_d = '0;
								tail_d = '0;
							end else if (pos_q == '0) begin
								head_d = nm_rn;
							end else if (pos_q == cnt_x - XW'(1)) begin
								tail_d = nm_rp;
							end else begin
								// unlink: prev.next = next now, next.prev = prev after
								nm_addr   = nm_rp;
								nm_cmd    = '{re: 1'b0, we_value: 1'b0, we_next: 1'b1,
									we_prev: 1'b0};
								nm_wn     = nm_rn;
								lp_addr_d = nm_rn;
								lp_val_d  = nm_rp;
								chain_d   = 1'b0;
								state_d   = ST_LINK_PREV;
							end
						end
						default: begin
							// insert before the located node
							nm_addr   = n_q;
							nm_cmd    = '{re: 1'b0, we_value: 1'b1, we_next: 1'b1, we_prev: 1'b1};
							nm_wn     = cur_q;
							nm_wp     = nm_rp;
							lp_addr_d = cur_q;
							lp_val_d  = n_q;
							ln_addr_d = nm_rp;
							ln_val_d  = n_q;
							chain_d   = 1'b1;
							cnt_d     = cnt_q + CW'(1);
							state_d   = ST_LINK_PREV;
						end
					endcase
				end
			end
			ST_FIND: begin
				if (nm_rv == val_q) begin
					fidx_d  = FIDX_W'(idx_q);
					state_d = ST_DONE;
				end else if (CW'(idx_q + CW'(1)) == cnt_q) begin
					status_d = STATUS_NOT_FOUND;
					state_d  = ST_DONE;
				end else begin
					nm_cmd.re = 1'b1;
					nm_addr   = nm_rn;
					idx_d     = idx_q + CW'(1);
				end
			end
			ST_LINK_PREV: begin
				nm_addr        = lp_addr_q;
				nm_cmd.we_prev = 1'b1;
				nm_wp          = lp_val_q;
				state_d        = chain_q ? ST_LINK_NEXT : ST_DONE;
			end
			ST_LINK_NEXT: begin
				nm_addr        = ln_addr_q;
				nm_cmd.we_next = 1'b1;
				nm_wn          = ln_val_q;
				state_d        = ST_DONE;
			end
			ST_DONE: begin
				if (!rsp_valid_q || rsp.ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			head_q  <= head_d;
			tail_q  <= tail_d;
			if (out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		kind_q    <= kind_d;
		val_q     <= val_d;
		pos_q     <= pos_d;
		cur_q     <= cur_d;
		steps_q   <= steps_d;
		dir_q     <= dir_d;
		idx_q     <= idx_d;
		n_q       <= n_d;
		lp_addr_q <= lp_addr_d;
		lp_val_q  <= lp_val_d;
		ln_addr_q <= ln_addr_d;
		ln_val_q  <= ln_val_d;
		chain_q   <= chain_d;
		status_q  <= status_d;
		rd_q      <= rd_d;
		fidx_q    <= fidx_d;
		if (out_load) begin
			rsp_status_q <= status_q;
			rsp_value_q  <= rd_q;
			rsp_fidx_q   <= fidx_q;
			rsp_count_q  <= COUNT_W'(cnt_q);
		end
	end

	// every slot is either on the list or on the free stack between ops
	a_slots_balance: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |->
			((CW+1)'(fs_top) + (CW+1)'(cnt_q)) == (CW+1)'(POOL_SLOTS))
		else $error("free stack and list count out of balance");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(POOL_SLOTS))
		else $error("element count above pool size");

	a_empty_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && cnt_q == '0) |-> (head_q == '0 && tail_q == '0))
		else $error("empty list with nonzero head or tail");

	a_accept_decide: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> state_q == ST_DECIDE)
		else $error("accepted transfer not decoded");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && !rsp.ready) |-> !out_load)
		else $error("pending result overwritten");

endmodule

>>> tb/tb_indexed_double_linked_list_unit.sv
module tb_indexed_double_linked_list_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import idll_pkg::*;

	// Cycles without any transfer before the run is declared hung.
	localparam int HANG_LIMIT   = 20000;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 200;
	localparam int RANDOM_ITEMS = 205;
	localparam kind_t KIND_LAST = 3'd7;

	typedef struct {
		status_t status;
		value_t  read_value;
		fidx_t   found_index;
		count_t  count;
	} list_result_t;

	logic clk;
	logic arst_n;

	idll_req_if req ();
	idll_rsp_if rsp ();

	indexed_double_linked_list_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.rsp    (rsp.source)
	);

	// Mirror of the list contents, head first.
	value_t       list_vals[$];
	list_result_t expected_results[$];

	int send_idle_pct;
	int recv_stall_pct;
	int hold_left;
	int errors;
	int quiet_cycles;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Apply one operation to the list mirror and work out its result.
	function automatic list_result_t apply_list_op(kind_t k, value_t v, pos_t p);
		list_result_t r;
		int           n;
		r.status      = STATUS_OK;
		r.read_value  = '0;
		r.found_index = '0;
		n = list_vals.size();
		case (k)
			KIND_INSERT: begin
				if (p > n)
					r.status = STATUS_RANGE;
				else if (n >= POOL_SLOTS_DEF)
					r.status = STATUS_FULL;
				else
					list_vals.insert(p, v);
			end
			KIND_DELETE: begin
				if (p >= n)
					r.status = STATUS_RANGE;
				else
					list_vals.delete(p);
			end
			KIND_READ: begin
				if (p >= n) begin
					r.status     = STATUS_RANGE;
					r.read_value = '1;
				end else begin
					r.read_value = list_vals[p];
				end
			end
			KIND_FIND: begin
				r.status = STATUS_NOT_FOUND;
				for (int i = 0; i < n; i++) begin
					if (list_vals[i] == v) begin
						r.status      = STATUS_OK;
						r.found_index = fidx_t'(i);
						break;
					end
				end
			end
			KIND_CLEAR: list_vals.delete();
			default: ;
		endcase
		r.count = count_t'(list_vals.size());
		return r;
	endfunction

	// Offer one op; returns once it has been transferred, at the next falling edge.
	task automatic send_op(kind_t k, value_t v, pos_t p);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(negedge clk);
		end
		req.valid    <= 1'b1;
		req.kind     <= k;
		req.value    <= v;
		req.position <= p;
		do
			@(posedge clk);
		while (!req.ready);
		expected_results.push_back(apply_list_op(k, v, p));
		@(negedge clk);
	endtask

	task automatic go_quiet();
		req.valid <= 1'b0;
		while (expected_results.size() != 0)
			@(negedge clk);
	endtask

	// Mostly positions that land inside the list; now and then any 9-bit value.
	function automatic pos_t pick_pos(int extra);
		if ($urandom_range(0, 9) == 0)
			return pos_t'($urandom);
		return pos_t'($urandom_range(0, list_vals.size() + extra - 1));
	endfunction

	// Small values give duplicates for find; full-width ones toggle every bit.
	function automatic value_t pick_value();
		if ($urandom_range(0, 1) == 0)
			return value_t'($urandom_range(0, 15));
		return value_t'($urandom);
	endfunction

	task automatic send_random_op();
		int     r;
		value_t v;
		r = $urandom_range(0, 99);
		if (r < 40) begin
			send_op(KIND_INSERT, pick_value(), pick_pos(1));
		end else if (r < 60) begin
			send_op(KIND_DELETE, pick_value(), pick_pos(0));
		end else if (r < 75) begin
			send_op(KIND_READ, pick_value(), pick_pos(0));
		end else if (r < 91) begin
			v = pick_value();
			if (list_vals.size() != 0 && $urandom_range(0, 9) < 7)
				v = list_vals[$urandom_range(0, list_vals.size() - 1)];
			send_op(KIND_FIND, v, pos_t'($urandom));
		end else if (r < 94) begin
			send_op(KIND_CLEAR, pick_value(), pos_t'($urandom));
		end else begin
			send_op(kind_t'($urandom_range(KIND_CLEAR + 1, KIND_LAST)), pick_value(),
				pos_t'($urandom));
		end
	endtask

	// Edge cases on an empty and a short list, every kind, field extremes.
	task automatic test_directed();
		send_op(KIND_FIND, 32'sd0, '0);                    // find on empty list
		send_op(KIND_READ, 32'sd0, '0);                    // read on empty list
		send_op(KIND_DELETE, 32'sd0, '0);                  // delete on empty list
		send_op(KIND_INSERT, 32'sd5, 9'd1);                // insert past the end
		send_op(KIND_INSERT, 32'h7fffffff, '0);            // first element
		send_op(KIND_INSERT, 32'h80000000, '0);            // new head
		send_op(KIND_INSERT, -32'sd1, 9'd2);               // new tail
		send_op(KIND_INSERT, 32'sd7, 9'd1);                // middle
		send_op(KIND_INSERT, 32'sd7, 9'd3);                // duplicate, middle
		send_op(KIND_READ, 32'sd0, 9'd0);
		send_op(KIND_READ, 32'sd0, 9'd4);
		send_op(KIND_READ, 32'sd0, 9'd2);
		send_op(KIND_READ, 32'sd0, 9'd511);                // bad index, all ones
		send_op(KIND_FIND, 32'sd7, '0);                    // first of duplicates
		send_op(KIND_FIND, -32'sd1, '0);
		send_op(KIND_FIND, 32'sd12345, '0);                // absent
		send_op(KIND_INSERT, 32'sd3, 9'd511);
		send_op(KIND_DELETE, 32'sd0, 9'd511);
		for (kind_t k = kind_t'(KIND_CLEAR + 1); k != KIND_INSERT; k++)
			send_op(k, 32'h55aa55aa, 9'h1aa);                // reserved kinds
		send_op(KIND_DELETE, 32'sd0, 9'd2);                // middle
		send_op(KIND_DELETE, 32'sd0, 9'd0);                // head
		send_op(KIND_DELETE, 32'sd0, 9'd2);                // tail
		send_op(KIND_CLEAR, 32'sd0, '0);
		send_op(KIND_INSERT, 32'sd9, '0);                  // reuse after clear
		send_op(KIND_DELETE, 32'sd0, '0);                  // last element
	endtask

	// Fill every slot, then push against the full pool.
	task automatic test_pool_full();
		send_op(KIND_CLEAR, 32'sd0, '0);
		while (list_vals.size() < POOL_SLOTS_DEF)
			send_op(KIND_INSERT, value_t'($urandom),
				pos_t'($urandom_range(0, list_vals.size())));
		send_op(KIND_INSERT, 32'sd1, '0);                  // full
		send_op(KIND_INSERT, 32'sd1, 9'd256);              // full at end
		send_op(KIND_INSERT, 32'sd1, 9'd257);              // range beats full
		send_op(KIND_READ, 32'sd0, 9'd255);
		send_op(KIND_READ, 32'sd0, 9'd127);
		send_op(KIND_READ, 32'sd0, 9'd128);
		send_op(KIND_READ, 32'sd0, 9'd256);
		send_op(KIND_FIND, list_vals[255], '0);            // deepest find
		send_op(KIND_DELETE, 32'sd0, 9'd128);
		send_op(KIND_INSERT, 32'sd2, 9'd200);              // slot comes back
		for (int i = 0; i < 20; i++)
			send_op(KIND_DELETE, 32'sd0, pick_pos(0));
		send_op(KIND_CLEAR, 32'sd0, '0);
	endtask

	// Receiver holds off for a long stretch while ops keep coming.
	task automatic test_backpressure();
		hold_left = HOLD_CYCLES;
		for (int i = 0; i < 12; i++)
			send_random_op();
	endtask

	task automatic test_random(int items, int idle_pct, int stall_pct);
		go_quiet();
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		for (int i = 0; i < items; i++)
			send_random_op();
	endtask

	// Receiver: random stalls, or a counted hold-off.
	always @(negedge clk) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else if (hold_left > 0) begin
			rsp.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else begin
			rsp.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// Compare each result transfer with the oldest expectation.
	always @(posedge clk) begin
		list_result_t e;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result status %0d count %0d",
					$time, rsp.status, rsp.count);
				errors++;
			end else begin
				e = expected_results.pop_front();
				if (rsp.status !== e.status || rsp.read_value !== e.read_value ||
					rsp.found_index !== e.found_index || rsp.count !== e.count) begin
					$display("%0t: exp st %0d rd %0d idx %0d cnt %0d, act st %0d rd %0d idx %0d cnt %0d",
						$time, e.status, e.read_value, e.found_index, e.count,
						rsp.status, rsp.read_value, rsp.found_index, rsp.count);
					errors++;
				end
			end
		end
	end

	// Hang watchdog: cycles without a transfer on either channel.
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= HANG_LIMIT) begin
			$display("indexed_double_linked_list_unit verification failed");
			$finish;
		end
	end

	initial begin
		errors         = 0;
		quiet_cycles   = 0;
		hold_left      = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		arst_n         = 1'b0;
		req.valid      = 1'b0;
		req.kind       = KIND_INSERT;
		req.value      = '0;
		req.position   = '0;
		rsp.ready      = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_pool_full();
		test_random(RANDOM_ITEMS, 0, 0);
		test_random(RANDOM_ITEMS, 67, 0);
		test_random(RANDOM_ITEMS, 0, 67);
		test_backpressure();
		test_random(RANDOM_ITEMS, 28, 28);

		go_quiet();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("indexed_double_linked_list_unit verification clean");
		else
			$display("indexed_double_linked_list_unit verification failed");
		$finish;
	end

endmodule
